### rtl/wla_pkg.sv
// ----------------------------------------------------------------------------
// wla_pkg: shared constants for the windowed load averager
// sample and register widths, register indexes, reset values, queue depth
// ----------------------------------------------------------------------------
package wla_pkg;

  localparam int SAMPLE_W        = 10;   // load sample width
  localparam int AVG_W           = 10;   // average width, also divider steps
  localparam int REG_W           = 11;   // configuration register width
  localparam int CFG_IDX_W       = 2;    // configuration register index width
  localparam int MAX_HISTORY_DEF = 1024; // default history depth
  localparam int QUEUE_DEPTH     = 2;    // job queue between front and back

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG  = 2'd3;

  // register reset values
  localparam logic [REG_W-1:0] RING_RST  = 11'd180;
  localparam logic [REG_W-1:0] SHORT_RST = 11'd12;
  localparam logic [REG_W-1:0] MID_RST   = 11'd60;
  localparam logic [REG_W-1:0] LONG_RST  = 11'd180;

endpackage

### rtl/wla_queue.sv
// ----------------------------------------------------------------------------
// wla_queue: small job queue
// first-in first-out store that decouples the classifying front from the
// summing back
// ----------------------------------------------------------------------------
module wla_queue import wla_pkg::*; #(
  parameter int  DEPTH  = QUEUE_DEPTH,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  item_t          slots_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]  num_q, num_d;

  assign full_o  = (num_q == NW'(DEPTH));
  assign empty_o = (num_q == '0);
  assign item_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    num_d = num_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      num_d = num_q + 1'b1;
    end else if (pop_i && !push_i) begin
      num_d = num_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= item_i;
    end
  end

endmodule

### rtl/wla_front.sv
// ----------------------------------------------------------------------------
// wla_front: sample intake and window classification
// holds the registers, the write position and the fill count, and turns each
// sample into a job with its slot and the three cut window lengths
// ----------------------------------------------------------------------------
module wla_front import wla_pkg::*; #(
  parameter int  MAX_HISTORY = MAX_HISTORY_DEF,
  parameter type job_t       = logic
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  load_sample_i,
  input  logic                 queue_full_i,
  output logic                 job_push_o,
  output job_t                 job_o
);

  localparam int AW = $clog2(MAX_HISTORY);
  localparam int CW = $clog2(MAX_HISTORY + 1);
  localparam int XW = (CW > REG_W) ? CW : REG_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_HISTORY);

  logic [REG_W-1:0] ring_q, short_q, mid_q, long_q;
  logic [AW-1:0]    wpos_q, wpos_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [XW-1:0]    ring_x;
  logic [CW-1:0]    len, pos, pos_inc;
  logic [CW-1:0]    n_s, n_m, n_l, n_sm;
  logic             accept;

  // window cut to at least one sample and at most the fill
  function automatic logic [CW-1:0] cut_window(input logic [REG_W-1:0] w,
                                               input logic [CW-1:0]    f);
    logic [XW-1:0] wx;
    wx = XW'(w);
    if (wx == '0) wx = XW'(1);
    if (wx > XW'(f)) wx = XW'(f);
    return wx[CW-1:0];
  endfunction

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign job_push_o = accept;

  always_comb begin
    ring_x = XW'(ring_q);
    if (ring_x == '0) ring_x = XW'(1);
    if (ring_x > MAX_X) ring_x = MAX_X;
    len = ring_x[CW-1:0];

    pos     = (CW'(wpos_q) >= len) ? '0 : CW'(wpos_q);
    pos_inc = pos + 1'b1;
    wpos_d  = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];
    fill_d  = (fill_q < len) ? fill_q + 1'b1 : len;

    n_s  = cut_window(short_q, fill_d);
    n_m  = cut_window(mid_q, fill_d);
    n_l  = cut_window(long_q, fill_d);
    n_sm = (n_s > n_m) ? n_s : n_m;

    job_o.sample = load_sample_i;
    job_o.newest = pos[AW-1:0];
    job_o.len    = len;
    job_o.n_s    = n_s;
    job_o.n_m    = n_m;
    job_o.n_l    = n_l;
    job_o.n_max  = (n_sm > n_l) ? n_sm : n_l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q  <= RING_RST;
      short_q <= SHORT_RST;
      mid_q   <= MID_RST;
      long_q  <= LONG_RST;
      wpos_q  <= '0;
      fill_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RING: begin
          ring_q <= cfg_wdata_i;
          wpos_q <= '0;
          fill_q <= '0;
        end
        REG_SHORT: short_q <= cfg_wdata_i;
        REG_MID:   mid_q   <= cfg_wdata_i;
        REG_LONG:  long_q  <= cfg_wdata_i;
        default: ;
      endcase
    end else if (accept) begin
      wpos_q <= wpos_d;
      fill_q <= fill_d;
    end
  end

endmodule

### rtl/wla_div.sv
// ----------------------------------------------------------------------------
// wla_div: iterative divider
// restoring division, one quotient bit per cycle, for quotients known to fit
// in AVG_W bits
// ----------------------------------------------------------------------------
module wla_div import wla_pkg::*; #(
  parameter int VW = 11,
  parameter int DW = VW + AVG_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW-1:0]    dividend_i,
  input  logic [VW-1:0]    divisor_i,
  output logic             done_o,
  output logic [AVG_W-1:0] quotient_o
);

  localparam int SCW = $clog2(AVG_W);

  logic [DW-1:0]    rem_q, dsh_q;
  logic [AVG_W-1:0] quo_q;
  logic [SCW-1:0]   step_q;
  logic             busy_q, done_q;
  logic             fits;

  assign fits       = (rem_q >= dsh_q);
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == SCW'(AVG_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (step_q == SCW'(AVG_W - 1))) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= DW'({divisor_i, {(AVG_W - 1){1'b0}}});
      quo_q  <= '0;
      step_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q  <= {quo_q[AVG_W-2:0], fits};
      dsh_q  <= dsh_q >> 1;
      step_q <= step_q + 1'b1;
    end
  end

endmodule

### rtl/wla_back.sv
// ----------------------------------------------------------------------------
// wla_back: history store, window sums and averages
// stores the sample, sweeps the history from newest to oldest summing the
// three windows, divides through the shared divider and holds the result
// ----------------------------------------------------------------------------
module wla_back import wla_pkg::*; #(
  parameter int  MAX_HISTORY = MAX_HISTORY_DEF,
  parameter type job_t       = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AVG_W-1:0] avg_short_o,
  output logic [AVG_W-1:0] avg_mid_o,
  output logic [AVG_W-1:0] avg_long_o
);

  localparam int AW = $clog2(MAX_HISTORY);
  localparam int CW = $clog2(MAX_HISTORY + 1);
  localparam int SW = SAMPLE_W + CW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [1:0] SEL_SHORT = 2'd0;
  localparam logic [1:0] SEL_MID   = 2'd1;
  localparam logic [1:0] SEL_LONG  = 2'd2;

  logic [SAMPLE_W-1:0] hist_mem [MAX_HISTORY];

  logic [1:0]          state_q, state_d;
  job_t                job_q, job_d;
  logic [AW-1:0]       ra_q, ra_d;
  logic [SAMPLE_W-1:0] rdata_q;
  logic                rvalid_q, rvalid_d;
  logic [CW-1:0]       issued_q, issued_d, cnt_q, cnt_d;
  logic [SW-1:0]       acc_q, acc_d;
  logic [SW-1:0]       sum_s_q, sum_s_d, sum_m_q, sum_m_d, sum_l_q, sum_l_d;
  logic [1:0]          sel_q, sel_d;
  logic                go_q, go_d;
  logic [AVG_W-1:0]    q_s_q, q_s_d, q_m_q, q_m_d, q_l_q, q_l_d;
  logic                out_valid_q, out_valid_d;
  logic [AVG_W-1:0]    out_s_q, out_m_q, out_l_q;
  logic                load_out, rd_en, mem_we;
  logic [SW-1:0]       div_num;
  logic [CW-1:0]       div_den;
  logic                div_done;
  logic [AVG_W-1:0]    div_quo;

  // one slot back in the ring, wrapping to the top slot in use
  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] a,
                                              input logic [CW-1:0] len);
    logic [CW-1:0] top;
    top = len - 1'b1;
    return (a == '0) ? top[AW-1:0] : a - 1'b1;
  endfunction

  assign out_valid_o = out_valid_q;
  assign avg_short_o = out_s_q;
  assign avg_mid_o   = out_m_q;
  assign avg_long_o  = out_l_q;

  always_comb begin
    case (sel_q)
      SEL_SHORT: begin
        div_num = sum_s_q;
        div_den = job_q.n_s;
      end
      SEL_MID: begin
        div_num = sum_m_q;
        div_den = job_q.n_m;
      end
      default: begin
        div_num = sum_l_q;
        div_den = job_q.n_l;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    ra_d      = ra_q;
    rvalid_d  = 1'b0;
    issued_d  = issued_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    sum_s_d   = sum_s_q;
    sum_m_d   = sum_m_q;
    sum_l_d   = sum_l_q;
    sel_d     = sel_q;
    go_d      = 1'b0;
    q_s_d     = q_s_q;
    q_m_d     = q_m_q;
    q_l_d     = q_l_q;
    job_pop_o = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          // newest sample goes straight into the sums, the sweep reads older ones
          job_pop_o = 1'b1;
          mem_we    = 1'b1;
          job_d     = job_i;
          acc_d     = SW'(job_i.sample);
          cnt_d     = CW'(1);
          issued_d  = CW'(1);
          ra_d      = prev_slot(job_i.newest, job_i.len);
          if (job_i.n_s == CW'(1)) sum_s_d = acc_d;
          if (job_i.n_m == CW'(1)) sum_m_d = acc_d;
          if (job_i.n_l == CW'(1)) sum_l_d = acc_d;
          if (job_i.n_max == CW'(1)) begin
            state_d = ST_DIV;
            sel_d   = SEL_SHORT;
            go_d    = 1'b1;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        rd_en = (issued_q < job_q.n_max);
        if (rd_en) begin
          issued_d = issued_q + 1'b1;
          ra_d     = prev_slot(ra_q, job_q.len);
        end
        rvalid_d = rd_en;
        if (rvalid_q) begin
          acc_d = acc_q + SW'(rdata_q);
          cnt_d = cnt_q + 1'b1;
          if (cnt_d == job_q.n_s) sum_s_d = acc_d;
          if (cnt_d == job_q.n_m) sum_m_d = acc_d;
          if (cnt_d == job_q.n_l) sum_l_d = acc_d;
          if (cnt_d == job_q.n_max) begin
            state_d = ST_DIV;
            sel_d   = SEL_SHORT;
            go_d    = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          case (sel_q)
            SEL_SHORT: q_s_d = div_quo;
            SEL_MID:   q_m_d = div_quo;
            default:   q_l_d = div_quo;
          endcase
          if (sel_q == SEL_LONG) begin
            state_d = ST_DONE;
          end else begin
            sel_d = sel_q + 1'b1;
            go_d  = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  wla_div #(
    .VW (CW),
    .DW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // all three averages move into the output register together
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_s_q <= q_s_q;
      out_m_q <= q_m_q;
      out_l_q <= q_l_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[job_i.newest] <= job_i.sample;
    end
    if (rd_en) begin
      rdata_q <= hist_mem[ra_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rvalid_q    <= 1'b0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rvalid_q    <= rvalid_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    ra_q     <= ra_d;
    issued_q <= issued_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    sum_s_q  <= sum_s_d;
    sum_m_q  <= sum_m_d;
    sum_l_q  <= sum_l_d;
    sel_q    <= sel_d;
    q_s_q    <= q_s_d;
    q_m_q    <= q_m_d;
    q_l_q    <= q_l_d;
  end

endmodule

### rtl/windowed_load_averager_unit.sv
// ----------------------------------------------------------------------------
// windowed_load_averager_unit: multi-window moving average of load samples
// one sample in, three truncated means (short, mid, long window) out
// ----------------------------------------------------------------------------
// Each accepted load sample is stored as the newest entry of a circular
// history ring_length slots long (zero counts as one, capped at MAX_HISTORY)
// and answered by one result: the floor of the mean of the newest
// short_window, mid_window and long_window samples, each window taken as at
// least one sample and cut to the number of samples stored since the ring
// length was last written. Writing ring_length empties the history; window
// writes keep it. Registers are to be written only while the block is idle;
// the block itself does not enforce this. For each item the sweep reads the
// older samples of the largest of the three cut windows through the single
// read port at one sample a cycle, then one divider working one quotient
// bit a cycle produces the three averages in turn. With the output register
// free the back end takes the next job in the cycle its result is offered.
// Two items queue in front of the back end and a finished result waits in
// its own output register, so up to four items may be in flight. After reset
// the block is ready at once; the history needs no clearing since unwritten
// slots are never read.
// ----------------------------------------------------------------------------
module windowed_load_averager_unit import wla_pkg::*; #(
  parameter int MAX_HISTORY = MAX_HISTORY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  // sample channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  load_sample_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [AVG_W-1:0]     avg_short_o,
  output logic [AVG_W-1:0]     avg_mid_o,
  output logic [AVG_W-1:0]     avg_long_o
);

  localparam int AW = $clog2(MAX_HISTORY);     // history slot address
  localparam int CW = $clog2(MAX_HISTORY + 1); // sample counts up to the depth

  // one queued job: the sample, its slot and the cut windows
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [AW-1:0]       newest;
    logic [CW-1:0]       len;
    logic [CW-1:0]       n_s;
    logic [CW-1:0]       n_m;
    logic [CW-1:0]       n_l;
    logic [CW-1:0]       n_max;
  } job_t;

  job_t front_job, back_job;
  logic job_push, job_pop, queue_full, queue_empty;

  // front: registers, write position, fill count, window cuts
  wla_front #(
    .MAX_HISTORY (MAX_HISTORY),
    .job_t       (job_t)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .load_sample_i (load_sample_i),
    .queue_full_i  (queue_full),
    .job_push_o    (job_push),
    .job_o         (front_job)
  );

  // short job queue so intake can go on during a sweep until the queue is full
  wla_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (job_t)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .item_i  (front_job),
    .full_o  (queue_full),
    .pop_i   (job_pop),
    .item_o  (back_job),
    .empty_o (queue_empty)
  );

  // back: history memory, window sums, divider, output register
  wla_back #(
    .MAX_HISTORY (MAX_HISTORY),
    .job_t       (job_t)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!queue_empty),
    .job_i       (back_job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .avg_short_o (avg_short_o),
    .avg_mid_o   (avg_mid_o),
    .avg_long_o  (avg_long_o)
  );

endmodule

### rtl/wla_checker.sv
// ----------------------------------------------------------------------------
// wla_checker: port-level checks for the windowed load averager
// tracks items in flight and checks results against them
// ----------------------------------------------------------------------------
module wla_checker import wla_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [AVG_W-1:0]     avg_short_o,
  input logic [AVG_W-1:0]     avg_mid_o,
  input logic [AVG_W-1:0]     avg_long_o
);

  // queue entries, the job in the back end and the output register
  localparam int MAX_PENDING = QUEUE_DEPTH + 2;
  localparam int PCW         = $clog2(MAX_PENDING + 2);

  logic [PCW-1:0] pending_q, pending_d;
  logic           in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) pending_d = pending_q + 1'b1;
    if (out_xfer && !in_xfer) pending_d = pending_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(avg_short_o)
      && $stable(avg_mid_o) && $stable(avg_long_o))
    else $error("result changed or dropped while stalled");

  // no result without an accepted sample behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result shown with no sample in flight");

  // intake stops once every stage holds an item
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q >= PCW'(MAX_PENDING) |-> !in_ready_o)
    else $error("sample taken with all stages occupied");

  // reset empties the result register
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind windowed_load_averager_unit wla_checker u_wla_checker (.*);

### tb/windowed_load_averager_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_load_averager_unit_tb: self-checking bench for the load averager
// feeds load samples over the input channel, mirrors the history ring and
// the three window means in a behavioural predictor, and checks every result
// transfer field by field under random idling, output hold-off and a series
// of register settings from the smallest to the largest
// ----------------------------------------------------------------------------
module windowed_load_averager_unit_tb;
  import wla_pkg::*;

  localparam int HIST_DEPTH      = MAX_HISTORY_DEF;
  localparam int CYCLE_LIMIT     = 5_000_000; // cycles before the watchdog ends the run
  localparam int RANDOM_ITEMS    = 800;
  localparam int HOLD_OFF_CYCLES = 600;       // far longer than four queued items
  localparam int DRAIN_CYCLES    = 100;
  localparam int IDLE_PERCENT    = 8;

  // one result transfer: the three truncated means
  typedef struct packed {
    logic [AVG_W-1:0] short_avg;
    logic [AVG_W-1:0] mid_avg;
    logic [AVG_W-1:0] long_avg;
  } averages_t;

  // ports
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [SAMPLE_W-1:0]  load_sample_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [AVG_W-1:0]     avg_short_o;
  logic [AVG_W-1:0]     avg_mid_o;
  logic [AVG_W-1:0]     avg_long_o;

  // predictor state: own copy of the history ring and the registers
  logic [SAMPLE_W-1:0] history_copy [HIST_DEPTH];
  int unsigned         next_slot;
  int unsigned         samples_held;
  logic [REG_W-1:0]    ring_cfg;
  logic [REG_W-1:0]    short_cfg;
  logic [REG_W-1:0]    mid_cfg;
  logic [REG_W-1:0]    long_cfg;

  // averages still owed by the block, oldest first
  averages_t expected_averages [$];

  // bookkeeping
  int  mismatch_count  = 0;
  int  samples_sent    = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  int  phases_run      = 0;
  int  cycle_count     = 0;
  bit  calm            = 1'b0; // no idling on either side while set
  int  hold_request    = 0;    // hold-off length handed to the receiver
  int  hold_left       = 0;

  windowed_load_averager_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .load_sample_i (load_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .avg_short_o   (avg_short_o),
    .avg_mid_o     (avg_mid_o),
    .avg_long_o    (avg_long_o)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d averages still owed", cycle_count,
             expected_averages.size());
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // ring length in use: zero counts as one slot, anything above the depth
  // is capped
  function automatic int unsigned slots_in_use();
    if (ring_cfg == '0) return 1;
    if (ring_cfg > HIST_DEPTH) return HIST_DEPTH;
    return 32'(ring_cfg);
  endfunction

  // floor of the mean over the newest samples, walking backwards from the
  // newest slot and wrapping at the ring length
  function automatic logic [AVG_W-1:0] newest_mean(logic [REG_W-1:0] window,
                                                   int unsigned newest,
                                                   int unsigned len);
    int unsigned n;
    int unsigned idx;
    int unsigned sum;
    n = (window == '0) ? 1 : 32'(window);
    if (n > samples_held) n = samples_held;
    if (n > len) n = len;
    if (n == 0) return '0;
    sum = 0;
    idx = newest;
    for (int unsigned k = 0; k < n; k++) begin
      sum += 32'(history_copy[idx]);
      idx = (idx == 0) ? len - 1 : idx - 1;
    end
    return AVG_W'(sum / n);
  endfunction

  // store one sample as the newest entry and work out the three means
  function automatic averages_t store_and_average(logic [SAMPLE_W-1:0] sample);
    int unsigned len;
    int unsigned newest;
    averages_t   avgs;
    len = slots_in_use();
    if (next_slot >= len) next_slot = 0;
    newest = next_slot;
    history_copy[newest] = sample;
    next_slot = (newest + 1 >= len) ? 0 : newest + 1;
    if (samples_held < len) samples_held++;
    if (samples_held > len) samples_held = len;
    avgs.short_avg = newest_mean(short_cfg, newest, len);
    avgs.mid_avg   = newest_mean(mid_cfg, newest, len);
    avgs.long_avg  = newest_mean(long_cfg, newest, len);
    return avgs;
  endfunction

  // --------------------------------------------------------------------------
  // drivers, all called just after a falling edge
  // --------------------------------------------------------------------------

  // one register write; the predictor mirror follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [REG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_RING: begin
        // any ring write empties the history, same value or not
        ring_cfg     = value;
        next_slot    = 0;
        samples_held = 0;
      end
      REG_SHORT: short_cfg = value;
      REG_MID:   mid_cfg   = value;
      REG_LONG:  long_cfg  = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // offer one sample and wait for its transfer; valid is left high so that
  // the next call can follow back to back
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    load_sample_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    expected_averages.push_back(store_and_average(sample));
    samples_sent++;
    @(negedge clk_i);
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_averages.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stalls, plus a hold-off counted here on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // --------------------------------------------------------------------------
  // result checker: each transfer against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    averages_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_averages.size() == 0) begin
        $error("result transfer with no averages expected: %0d %0d %0d",
               avg_short_o, avg_mid_o, avg_long_o);
        mismatch_count++;
      end else begin
        want = expected_averages.pop_front();
        results_checked++;
        if (avg_short_o !== want.short_avg) begin
          $error("avg_short: expected %0d, actual %0d", want.short_avg, avg_short_o);
          mismatch_count++;
        end
        if (avg_mid_o !== want.mid_avg) begin
          $error("avg_mid: expected %0d, actual %0d", want.mid_avg, avg_mid_o);
          mismatch_count++;
        end
        if (avg_long_o !== want.long_avg) begin
          $error("avg_long: expected %0d, actual %0d", want.long_avg, avg_long_o);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // random pickers
  // --------------------------------------------------------------------------

  // mostly short rings so the ring wraps often, sometimes the extremes
  function automatic logic [REG_W-1:0] pick_ring();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 16) return REG_W'($urandom_range(41, 2047));
    if (r < 20) return ($urandom_range(1) != 0) ? 11'd2047 : 11'd1024;
    return REG_W'($urandom_range(1, 40));
  endfunction

  function automatic logic [REG_W-1:0] pick_window();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return REG_W'($urandom_range(0, 2047));
    if (r < 25) return 11'd2047;
    return REG_W'($urandom_range(1, 48));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 16) return '1;
    return SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset settings, short window still cut to the fill
  task automatic test_reset_defaults();
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
  endtask

  // ring above the depth is capped, window zero means one sample,
  // windows far beyond the fill are cut
  task automatic test_register_extremes();
    drain_results();
    write_reg(REG_RING, 11'd2047);
    write_reg(REG_SHORT, 11'd0);
    write_reg(REG_MID, 11'd2047);
    write_reg(REG_LONG, 11'd1024);
    send_sample(10'd1023);
    send_sample(10'd1023);
    send_sample(10'd0);
  endtask

  // ring length zero behaves as a single slot
  task automatic test_single_slot_ring();
    drain_results();
    write_reg(REG_RING, 11'd0);
    write_reg(REG_SHORT, 11'd1);
    write_reg(REG_MID, 11'd2);
    write_reg(REG_LONG, 11'd3);
    send_sample(10'd7);
    send_sample(10'd1023);
    send_sample(10'd0);
  endtask

  // three-slot ring wrapping, long window above the ring length
  task automatic test_ring_wraparound();
    drain_results();
    write_reg(REG_RING, 11'd3);
    write_reg(REG_SHORT, 11'd2);
    write_reg(REG_MID, 11'd3);
    write_reg(REG_LONG, 11'd5);
    send_sample(10'd100);
    send_sample(10'd200);
    send_sample(10'd300);
    send_sample(10'd400);
    send_sample(10'd1023);
  endtask

  // writing the unchanged ring length still empties the history
  task automatic test_ring_rewrite_clears();
    drain_results();
    write_reg(REG_RING, 11'd3);
    send_sample(10'd5);
    send_sample(10'd6);
  endtask

  // a window write keeps the stored samples
  task automatic test_window_rewrite_keeps_history();
    drain_results();
    write_reg(REG_SHORT, 11'd3);
    send_sample(10'd9);
    send_sample(10'd1023);
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    drain_results();
    write_reg(REG_RING, 11'd16);
    calm = 1'b1;
    @(posedge clk_i);
    hold_request = HOLD_OFF_CYCLES;
    @(negedge clk_i);
    repeat (10) send_sample(pick_sample());
    drain_results();
    calm = 1'b0;
  endtask

  // random phases: new settings between phases, random sample runs inside
  task automatic test_random_phases();
    int  phase;
    int  items;
    int  target;
    bit  saturate;
    phase  = 0;
    target = samples_sent + RANDOM_ITEMS;
    while (samples_sent < target) begin
      drain_results();
      calm = 1'b0;
      // keeping the ring now and then lets the fill build up over phases
      if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_RING, pick_ring());
      if ($urandom_range(4) != 0) write_reg(REG_SHORT, pick_window());
      if ($urandom_range(4) != 0) write_reg(REG_MID, pick_window());
      if ($urandom_range(4) != 0) write_reg(REG_LONG, pick_window());
      // one phase runs with no idling at all
      calm     = (phase == 3);
      saturate = ($urandom_range(9) == 0);
      items    = (phase == 3) ? 80 : $urandom_range(10, 60);
      repeat (items) send_sample(saturate ? '1 : pick_sample());
      phase++;
    end
    drain_results();
    calm       = 1'b0;
    phases_run = phase;
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    // every input known from time zero, reset held low
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_RING;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    load_sample_i = '0;
    out_ready_i   = 1'b0;
    // predictor after reset
    ring_cfg      = RING_RST;
    short_cfg     = SHORT_RST;
    mid_cfg       = MID_RST;
    long_cfg      = LONG_RST;
    next_slot     = 0;
    samples_held  = 0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_single_slot_ring();
    test_ring_wraparound();
    test_ring_rewrite_clears();
    test_window_rewrite_keeps_history();
    test_output_backpressure();
    test_random_phases();

    // anything arriving late or uninvited shows up in the checker here
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d samples transferred, %0d result transfers checked, %0d mismatches",
             samples_sent, results_checked, mismatch_count);
    $display("%0d register writes over %0d random phases plus directed ring cases",
             reg_writes, phases_run);
    if (mismatch_count == 0 && expected_averages.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
